// ===== sv/fvs_pkg.sv =====
// ----------------------------------------------------------------------------
// fvs_pkg
// Shared constants, step codes, control structs and tables of the formant
// voice synthesizer.
// ----------------------------------------------------------------------------
package fvs_pkg;

    localparam int SAMPLE_RATE = 16000;

    localparam int OP_W     = 2;
    localparam int F0_W     = 12;
    localparam int VOWEL_W  = 8;
    localparam int DUR_W    = 10;
    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 2;

    localparam logic [OP_W-1:0] OP_BEGIN     = 2'd0;
    localparam logic [OP_W-1:0] OP_BEGIN_NEW = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK      = 2'd2;

    localparam int COUNT_W = $clog2(((1 << DUR_W) - 1) * SAMPLE_RATE / 1000 + 1);
    localparam int DIV_W   = (COUNT_W + 23 > 37) ? COUNT_W + 23 : 37;
    localparam int DVR_W   = COUNT_W + 5;

    localparam int PHASE_W = 24;
    localparam logic [PHASE_W:0] PHASE_ONE    = 25'd16777216;
    localparam logic [PHASE_W:0] PULSE_WINDOW = 25'd1342177;
    localparam logic [21:0]      VIB_STEP     = 22'd3076033;

    // phase increment / 16000: shift out 2^7, then multiply by ceil(2^37 / 125)
    localparam int          INC_PRE_SHIFT = 7;
    localparam logic [30:0] INC_RECIP     = 31'd1099511628;
    localparam int          INC_SHIFT     = 37;

    localparam logic [2:0] VOWEL_NONE = 3'd7;
    localparam logic [1:0] VOL_RESET  = 2'd2;
    localparam int         CLIP_LEVEL = 20000;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] S_IDLE  = 6'd0;
    localparam logic [STEP_W-1:0] S_BDIV  = 6'd1;
    localparam logic [STEP_W-1:0] S_BWAIT = 6'd2;
    localparam logic [STEP_W-1:0] S_BSET  = 6'd3;
    localparam logic [STEP_W-1:0] S_T_M1  = 6'd4;
    localparam logic [STEP_W-1:0] S_T_M2  = 6'd5;
    localparam logic [STEP_W-1:0] S_T_DIVF = 6'd6;
    localparam logic [STEP_W-1:0] S_T_WF  = 6'd7;
    localparam logic [STEP_W-1:0] S_T_VA  = 6'd8;
    localparam logic [STEP_W-1:0] S_T_VB  = 6'd9;
    localparam logic [STEP_W-1:0] S_T_VC  = 6'd10;
    localparam logic [STEP_W-1:0] S_T_VD  = 6'd11;
    localparam logic [STEP_W-1:0] S_T_MI  = 6'd12;
    localparam logic [STEP_W-1:0] S_T_DIVI = 6'd13;
    localparam logic [STEP_W-1:0] S_T_WI  = 6'd14;
    localparam logic [STEP_W-1:0] S_T_PH  = 6'd15;
    localparam logic [STEP_W-1:0] S_T_R1A = 6'd16;
    localparam logic [STEP_W-1:0] S_T_R1B = 6'd17;
    localparam logic [STEP_W-1:0] S_T_R1C = 6'd18;
    localparam logic [STEP_W-1:0] S_T_R2A = 6'd19;
    localparam logic [STEP_W-1:0] S_T_R2B = 6'd20;
    localparam logic [STEP_W-1:0] S_T_R2C = 6'd21;
    localparam logic [STEP_W-1:0] S_T_MX1 = 6'd22;
    localparam logic [STEP_W-1:0] S_T_MX2 = 6'd23;
    localparam logic [STEP_W-1:0] S_T_EC  = 6'd24;
    localparam logic [STEP_W-1:0] S_T_DIVE = 6'd25;
    localparam logic [STEP_W-1:0] S_T_WE  = 6'd26;
    localparam logic [STEP_W-1:0] S_T_E2  = 6'd27;
    localparam logic [STEP_W-1:0] S_T_SC1 = 6'd28;
    localparam logic [STEP_W-1:0] S_T_SC2 = 6'd29;
    localparam logic [STEP_W-1:0] S_T_SM1 = 6'd30;
    localparam logic [STEP_W-1:0] S_T_OUT = 6'd31;

    typedef struct packed {
        logic [STEP_W-1:0] step;
        logic              accept;
        logic              out_load;
    } fvs_cmd_t;

    typedef struct packed {
        logic active;
        logic vol_zero;
        logic env_flat;
        logic div_done;
        logic out_full;
    } fvs_status_t;

    function automatic logic signed [15:0] b1_coef(input logic [2:0] vw, input logic sel);
        logic signed [15:0] c;
        case ({vw, sel})
            4'b000_0: c = 16'sd29016;
            4'b000_1: c = 16'sd24125;
            4'b001_0: c = 16'sd30864;
            4'b001_1: c = 16'sd16043;
            4'b010_0: c = 16'sd31633;
            4'b010_1: c = 16'sd7944;
            4'b011_0: c = 16'sd30864;
            4'b011_1: c = 16'sd28111;
            4'b100_0: c = 16'sd31476;
            4'b100_1: c = 16'sd28902;
            default:  c = 16'sd29016;
        endcase
        return c;
    endfunction

    function automatic logic signed [15:0] b2_coef(input logic sel);
        return sel ? -16'sd15569 : -16'sd15691;
    endfunction

    function automatic logic [15:0] qsine(input logic [4:0] idx);
        logic [15:0] s;
        case (idx)
            5'd0:  s = 16'd0;
            5'd1:  s = 16'd3212;
            5'd2:  s = 16'd6393;
            5'd3:  s = 16'd9512;
            5'd4:  s = 16'd12540;
            5'd5:  s = 16'd15447;
            5'd6:  s = 16'd18205;
            5'd7:  s = 16'd20788;
            5'd8:  s = 16'd23170;
            5'd9:  s = 16'd25330;
            5'd10: s = 16'd27246;
            5'd11: s = 16'd28899;
            5'd12: s = 16'd30274;
            5'd13: s = 16'd31357;
            5'd14: s = 16'd32138;
            5'd15: s = 16'd32610;
            default: s = 16'd32768;
        endcase
        return s;
    endfunction

    function automatic logic [11:0] level_gain(input logic [VOL_W-1:0] lv);
        logic [11:0] g;
        case (lv)
            2'd1:    g = 12'd576;
            2'd2:    g = 12'd1440;
            2'd3:    g = 12'd2880;
            default: g = 12'd0;
        endcase
        return g;
    endfunction

endpackage

// ===== sv/fvs_if.sv =====
// ----------------------------------------------------------------------------
// fvs_if
// Valid/ready channels of the formant voice synthesizer.
// ----------------------------------------------------------------------------
interface fvs_in_if import fvs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [F0_W-1:0]    f0_start;
    logic [F0_W-1:0]    f0_end;
    logic [VOWEL_W-1:0] vowel;
    logic [DUR_W-1:0]   duration_ms;
    modport source (output valid, operation, f0_start, f0_end, vowel, duration_ms,
                    input ready);
    modport sink (input valid, operation, f0_start, f0_end, vowel, duration_ms,
                  output ready);
endinterface

interface fvs_out_if import fvs_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_syllable;
    modport source (output valid, sample, last_of_syllable, input ready);
    modport sink (input valid, sample, last_of_syllable, output ready);
endinterface

interface fvs_cfg_if import fvs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VOL_W-1:0] volume_level;
    modport source (output valid, volume_level, input ready);
    modport sink (input valid, volume_level, output ready);
endinterface

// ===== sv/fvs_divider.sv =====
// ----------------------------------------------------------------------------
// fvs_divider
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fvs_divider import fvs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVR_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVR_W-1:0] rem_reg;
    logic [DVR_W-1:0] dvr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVR_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DVR_W'(trial - {1'b0, dvr_reg}) : trial[DVR_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/fvs_datapath.sv =====
// ----------------------------------------------------------------------------
// fvs_datapath
// Voice state, pitch/vibrato/excitation, resonators, envelope and output.
// ----------------------------------------------------------------------------
module fvs_datapath import fvs_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fvs_cmd_t                   cmd,
    output fvs_status_t                status,
    input  logic [OP_W-1:0]            in_operation,
    input  logic [F0_W-1:0]            in_f0_start,
    input  logic [F0_W-1:0]            in_f0_end,
    input  logic [VOWEL_W-1:0]         in_vowel,
    input  logic [DUR_W-1:0]           in_duration_ms,
    input  logic                       cfg_write,
    input  logic [VOL_W-1:0]           cfg_volume,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_sample,
    output logic                       out_last
);

    localparam int P100_W = COUNT_W + 7;

    logic [VOL_W-1:0]    vol_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic signed [23:0]  z1a_reg, z1b_reg, z2a_reg, z2b_reg;
    logic [2:0]          vowel_reg;
    logic [COUNT_W-1:0]  pos_reg, cnt_reg;
    logic [F0_W-1:0]     pf_reg, pt_reg, f0a_reg, f0b_reg;
    logic                active_reg;
    logic [VOWEL_W-1:0]  vin_reg;
    logic [DUR_W-1:0]    ms_hold;
    logic                out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                last_reg;

    logic [F0_W+COUNT_W-1:0] wa_reg;
    logic [F0_W+COUNT_W:0]   wb_reg;
    logic [31:0]         ang_reg;
    logic [4:0]          idx_reg;
    logic [1:0]          quad_reg;
    logic [27:0]         interp_reg;
    logic [25:0]         magp_reg;
    logic [16:0]         vib_reg;
    logic [36:0]         incp_reg;
    logic [60:0]         incm_reg;
    logic [PHASE_W-1:0]  inc_reg;
    logic [16:0]         exc_reg;
    logic signed [39:0]  ra_reg;
    logic signed [40:0]  racc_reg;
    logic signed [38:0]  mixa_reg;
    logic signed [39:0]  mix_reg;
    logic                elo_reg, ehi_reg;
    logic [16:0]         env2_reg;
    logic signed [52:0]  scp_reg;
    logic signed [38:0]  scaled_reg;
    logic signed [56:0]  smpp_reg;

    logic [DIV_W-1:0]    div_dividend, div_q;
    logic [DVR_W-1:0]    div_divisor;
    logic                div_start, div_done;

    logic [15:0]         vprod;
    logic [7:0]          vrem;
    logic [2:0]          vmod, vw;
    logic [COUNT_W-1:0]  left;
    logic [P100_W-1:0]   p100, r100, t12, t28, t72;
    logic [16:0]         pq;
    logic [4:0]          vidx;
    logic [15:0]         vdiff, vs;
    logic [10:0]         vmag;
    logic [PHASE_W+1:0]  ph;
    logic signed [40:0]  radj;
    logic signed [27:0]  ysum;
    logic signed [23:0]  ysat;
    logic [16:0]         env_e;
    logic [33:0]         env_sq;
    logic signed [52:0]  scadj;
    logic signed [56:0]  smadj;
    logic signed [24:0]  smp;
    logic signed [SAMPLE_W-1:0] smp_clip;
    logic [COUNT_W:0]    pos_inc;

    always_comb
    begin
        vprod = 16'(vin_reg) * 16'd205;
        vrem  = vin_reg - 8'(vprod[15:10]) * 8'd5;
        vmod  = vrem[2:0];
        vw    = (vowel_reg < 3'd5) ? vowel_reg : 3'd0;
        left  = cnt_reg - pos_reg;
        p100  = P100_W'(pos_reg) * P100_W'(100);
        r100  = P100_W'(left) * P100_W'(100);
        t12   = P100_W'(cnt_reg) * P100_W'(12);
        t28   = P100_W'(cnt_reg) * P100_W'(28);
        t72   = P100_W'(cnt_reg) * P100_W'(72);
        pq    = ang_reg[30] ? (17'h10000 - {1'b0, ang_reg[29:14]}) : {1'b0, ang_reg[29:14]};
        vidx  = pq[16:12];
        vdiff = qsine(5'(vidx + 5'd1)) - qsine(vidx);
        vs    = (idx_reg >= 5'd16) ? 16'd32768 : qsine(idx_reg) + interp_reg[27:12];
        vmag  = magp_reg[25:15];
        ph    = {2'b00, phase_reg} + {2'b00, inc_reg};
        radj  = racc_reg + (racc_reg[40] ? 41'sd16383 : 41'sd0);
        ysum  = 28'($signed(radj[40:14])) + $signed({11'b0, exc_reg});
        if (ysum > 28'sd8388607)
            ysat = 24'sh7FFFFF;
        else if (ysum < -28'sd8388608)
            ysat = -24'sh800000;
        else
            ysat = ysum[23:0];
        env_e  = (elo_reg || ehi_reg) ? div_q[16:0] : 17'h10000;
        env_sq = 34'(env_e) * 34'(env_e);
        scadj  = scp_reg + (scp_reg[52] ? 53'sd16383 : 53'sd0);
        smadj  = smpp_reg + (smpp_reg[56] ? 57'sd4294967295 : 57'sd0);
        smp    = smadj[56:32];
        if (smp > 25'sd20000)
            smp_clip = 16'sd20000;
        else if (smp < -25'sd20000)
            smp_clip = -16'sd20000;
        else
            smp_clip = smp[SAMPLE_W-1:0];
        pos_inc = {1'b0, pos_reg} + 1'b1;
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.step)
            S_T_DIVF:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({wb_reg, 8'b0});
                div_divisor  = DVR_W'(cnt_reg);
            end
            S_T_DIVE:
            begin
                div_start    = elo_reg || ehi_reg;
                div_dividend = elo_reg ? DIV_W'({p100, 16'b0}) : DIV_W'({r100, 16'b0});
                div_divisor  = elo_reg ? DVR_W'(t12) : DVR_W'(t28);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    fvs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg       <= VOL_RESET;
            phase_reg     <= '0;
            z1a_reg       <= '0;
            z1b_reg       <= '0;
            z2a_reg       <= '0;
            z2b_reg       <= '0;
            vowel_reg     <= VOWEL_NONE;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            pf_reg        <= '0;
            pt_reg        <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                vol_reg <= cfg_volume;
            if (out_valid_reg && out_ready && !cmd.out_load)
                out_valid_reg <= 1'b0;
            case (cmd.step)
                S_IDLE:
                begin
                    if (cmd.accept)
                    begin
                        if (in_operation == OP_BEGIN_NEW)
                        begin
                            phase_reg <= '0;
                            z1a_reg   <= '0;
                            z1b_reg   <= '0;
                            z2a_reg   <= '0;
                            z2b_reg   <= '0;
                            vowel_reg <= VOWEL_NONE;
                        end
                        if ((in_operation == OP_BEGIN || in_operation == OP_BEGIN_NEW)
                            && (vol_reg == '0 || in_duration_ms == '0))
                            active_reg <= 1'b0;
                        if (in_operation == OP_TICK && vol_reg == '0)
                            active_reg <= 1'b0;
                    end
                end
                S_BSET:
                begin
                    vowel_reg  <= vmod;
                    pf_reg     <= f0a_reg;
                    pt_reg     <= f0b_reg;
                    cnt_reg    <= COUNT_W'(32'(ms_hold) * 32'(SAMPLE_RATE / 1000));
                    pos_reg    <= '0;
                    active_reg <= 1'b1;
                end
                S_T_PH:
                begin
                    if (ph >= (PHASE_W+2)'(PHASE_ONE))
                        phase_reg <= PHASE_W'(ph - (PHASE_W+2)'(PHASE_ONE));
                    else
                        phase_reg <= ph[PHASE_W-1:0];
                end
                S_T_R1C:
                begin
                    z1b_reg <= z1a_reg;
                    z1a_reg <= ysat;
                end
                S_T_R2C:
                begin
                    z2b_reg <= z2a_reg;
                    z2a_reg <= ysat;
                end
                S_T_OUT:
                begin
                    if (cmd.out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        pos_reg       <= pos_inc[COUNT_W-1:0];
                        if (pos_inc >= {1'b0, cnt_reg})
                            active_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ms_hold <= in_duration_ms;
            vin_reg <= in_vowel;
            f0a_reg <= in_f0_start;
            f0b_reg <= in_f0_end;
        end
        case (cmd.step)
            S_T_M1:  wa_reg <= (F0_W+COUNT_W)'(pf_reg) * (F0_W+COUNT_W)'(left);
            S_T_M2:  wb_reg <= (F0_W+COUNT_W+1)'(wa_reg)
                               + (F0_W+COUNT_W+1)'(pt_reg) * (F0_W+COUNT_W+1)'(pos_reg);
            S_T_VA:
            begin
                ang_reg <= 32'(54'(pos_reg) * 54'(VIB_STEP));
            end
            S_T_VB:
            begin
                idx_reg    <= vidx;
                quad_reg   <= ang_reg[31:30];
                interp_reg <= 28'(vdiff) * 28'(pq[11:0]);
            end
            S_T_VC:  magp_reg <= 26'(vs) * 26'd786;
            S_T_VD:  vib_reg <= quad_reg[1] ? (17'h10000 - 17'(vmag))
                                            : (17'h10000 + 17'(vmag));
            S_T_MI:  incp_reg <= 37'(div_q[19:0]) * 37'(vib_reg);
            S_T_DIVI: incm_reg <= 61'(incp_reg[36:INC_PRE_SHIFT]) * 61'(INC_RECIP);
            S_T_WI:  inc_reg <= incm_reg[60:INC_SHIFT];
            S_T_PH:
            begin
                if (ph >= (PHASE_W+2)'(PHASE_ONE))
                    exc_reg <= 17'd65536;
                else if (ph < (PHASE_W+2)'(PULSE_WINDOW))
                    exc_reg <= 17'd22938;
                else
                    exc_reg <= 17'd0;
            end
            S_T_R1A: ra_reg <= b1_coef(vw, 1'b0) * z1a_reg;
            S_T_R1B: racc_reg <= ra_reg + b2_coef(1'b0) * z1b_reg;
            S_T_R2A: ra_reg <= b1_coef(vw, 1'b1) * z2a_reg;
            S_T_R2B: racc_reg <= ra_reg + b2_coef(1'b1) * z2b_reg;
            S_T_MX1: mixa_reg <= z1a_reg * 15'sd12288;
            S_T_MX2: mix_reg <= mixa_reg + z2a_reg * 14'sd7373;
            S_T_EC:
            begin
                elo_reg <= p100 < t12;
                ehi_reg <= p100 > t72;
            end
            S_T_E2:  env2_reg <= env_sq[32:16];
            S_T_SC1: scp_reg <= mix_reg * $signed({1'b0, level_gain(vol_reg)});
            S_T_SC2: scaled_reg <= scadj[52:14];
            S_T_SM1: smpp_reg <= scaled_reg * $signed({1'b0, env2_reg});
            S_T_OUT:
            begin
                if (cmd.out_load)
                begin
                    sample_reg <= smp_clip;
                    last_reg   <= pos_inc == {1'b0, cnt_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.active   = active_reg;
    assign status.vol_zero = vol_reg == '0;
    assign status.env_flat = !elo_reg && !ehi_reg;
    assign status.div_done = div_done;
    assign status.out_full = out_valid_reg;

    assign out_valid  = out_valid_reg;
    assign out_sample = sample_reg;
    assign out_last   = last_reg;

`ifndef NO_ASSERTIONS
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg <= 16'sd20000 && sample_reg >= -16'sd20000))
        else $error("sample outside clip range");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> pos_reg < cnt_reg)
        else $error("sample position past syllable end");
    a_vowel: assert property (@(posedge clk) disable iff (!rst_n)
        vowel_reg < 3'd5 || vowel_reg == VOWEL_NONE)
        else $error("bad current vowel");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> active_reg && !(out_valid_reg && !out_ready))
        else $error("sample produced without a running syllable or free output");
`endif

endmodule

// ===== sv/fvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// fvs_ctrl
// Sequencer of the synthesizer: input handshake and per-sample step order.
// ----------------------------------------------------------------------------
module fvs_ctrl import fvs_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [OP_W-1:0] in_operation,
    input  logic            in_ms_zero,
    input  logic            out_ready,
    input  fvs_status_t     status,
    output fvs_cmd_t        cmd
);

    logic [STEP_W-1:0] state_reg, state_next;
    logic              accept;
    logic              out_free;

    assign in_ready = state_reg == S_IDLE;
    assign accept   = in_valid && in_ready;
    assign out_free = !status.out_full || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if ((in_operation == OP_BEGIN || in_operation == OP_BEGIN_NEW)
                        && !status.vol_zero && !in_ms_zero)
                        state_next = S_BDIV;
                    else if (in_operation == OP_TICK && status.active && !status.vol_zero)
                        state_next = S_T_M1;
                end
            end
            S_BSET:   state_next = S_IDLE;
            S_T_WF:   if (status.div_done) state_next = S_T_VA;
            S_T_DIVE: state_next = status.env_flat ? S_T_E2 : S_T_WE;
            S_T_WE:   if (status.div_done) state_next = S_T_E2;
            S_T_OUT:  if (out_free) state_next = S_IDLE;
            S_BDIV, S_BWAIT, S_T_M1, S_T_M2, S_T_DIVF, S_T_VA, S_T_VB, S_T_VC, S_T_VD,
            S_T_MI, S_T_DIVI, S_T_WI, S_T_PH, S_T_R1A, S_T_R1B, S_T_R1C, S_T_R2A,
            S_T_R2B, S_T_R2C, S_T_MX1, S_T_MX2, S_T_EC, S_T_E2, S_T_SC1,
            S_T_SC2, S_T_SM1:
                state_next = state_reg + 1'b1;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd.step     = state_reg;
    assign cmd.accept   = accept;
    assign cmd.out_load = (state_reg == S_T_OUT) && out_free;

endmodule

// ===== sv/formant_voice_synthesizer.sv =====
// Sequence: a begin-syllable transaction steps through S_BDIV, S_BWAIT and S_BSET, then idle.
// A tick producing a sample runs the per-sample steps up to S_T_OUT, which loads the output
// register once it is free; the passes of the shared divider (one with a flat envelope) dominate.
// One transaction at a time, a new one taken only in idle; ignored items leave the sequencer idle.
// Reset (rst_n, async, active low): volume medium, silent and idle, vowel none.
// ----------------------------------------------------------------------------
// formant_voice_synthesizer
// Two-resonator formant vowel synthesizer with pitch sweep and envelope.
// ----------------------------------------------------------------------------
module formant_voice_synthesizer import fvs_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    fvs_in_if.sink     syl_in,
    fvs_out_if.source  smp_out,
    fvs_cfg_if.sink    cfg
);

    fvs_cmd_t    cmd;
    fvs_status_t status;

    assign cfg.ready = 1'b1;

    fvs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (syl_in.valid),
        .in_ready     (syl_in.ready),
        .in_operation (syl_in.operation),
        .in_ms_zero   (syl_in.duration_ms == '0),
        .out_ready    (smp_out.ready),
        .status       (status),
        .cmd          (cmd)
    );

    fvs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_operation   (syl_in.operation),
        .in_f0_start    (syl_in.f0_start),
        .in_f0_end      (syl_in.f0_end),
        .in_vowel       (syl_in.vowel),
        .in_duration_ms (syl_in.duration_ms),
        .cfg_write      (cfg.valid),
        .cfg_volume     (cfg.volume_level),
        .out_valid      (smp_out.valid),
        .out_ready      (smp_out.ready),
        .out_sample     (smp_out.sample),
        .out_last       (smp_out.last_of_syllable)
    );

endmodule

// ===== bench/formant_voice_synthesizer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// formant_voice_synthesizer_tb
// Drives syllable, tick and volume transactions into the formant voice
// synthesizer with random idling on both channels. A bit-exact voice model
// in the bench predicts each sample, which is checked field by field.
// ----------------------------------------------------------------------------
module formant_voice_synthesizer_tb;
    import fvs_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } voice_sample_t;

    localparam int  HALF_PERIOD = 5;
    localparam int  SETTLE      = 200;
    localparam int  LONG_HOLD   = 600;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int unsigned  PULSE_Q16  = 22938;
    localparam int unsigned  GLOTTAL    = 65536;
    localparam longint       STATE_HI   = 8388607;
    localparam longint       STATE_LO   = -8388608;

    const int f1_b1[5]   = '{29016, 30864, 31633, 30864, 31476};
    const int f2_b1[5]   = '{24125, 16043, 7944, 28111, 28902};
    const int pole_b2[2] = '{-15691, -15569};
    const int sine_q15[17] = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                               25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
    const longint level_k[4] = '{0, 576, 1440, 2880};

    logic clk;
    logic rst_n;

    fvs_in_if  syl_in ();
    fvs_out_if smp_out ();
    fvs_cfg_if cfg ();

    formant_voice_synthesizer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .syl_in  (syl_in.sink),
        .smp_out (smp_out.source),
        .cfg     (cfg.sink)
    );

    // voice model state
    logic [VOL_W-1:0] vol;
    int unsigned      phase;
    longint           res1 [2];
    longint           res2 [2];
    int unsigned      cur_vowel;
    int unsigned      pos;
    int unsigned      count;
    int unsigned      pitch_a;
    int unsigned      pitch_b;
    bit               armed;

    voice_sample_t    pending_samples [$];
    int               errors;
    bit               calm;
    bit               hold_req;

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    function automatic int unsigned vib_gain(input int unsigned turns);
        int unsigned quad, p, idx, frac, mag;
        int s;
        quad = turns >> 30;
        p = (turns >> 14) & 32'hFFFF;
        if (quad & 1) p = 65536 - p;
        idx = p >> 12;
        frac = p & 32'hFFF;
        if (idx >= 16) s = sine_q15[16];
        else s = sine_q15[idx] + ((sine_q15[idx+1] - sine_q15[idx]) * frac >> 12);
        mag = (s * 786) >> 15;
        return (quad & 2) ? 65536 - mag : 65536 + mag;
    endfunction

    function automatic longint resonate(ref longint z[2], input longint b1, input longint b2,
                                        input longint x);
        longint acc, y;
        acc = b1 * z[0] + b2 * z[1];
        y = x + acc / 16384;
        if (y > STATE_HI) y = STATE_HI;
        if (y < STATE_LO) y = STATE_LO;
        z[1] = z[0];
        z[0] = y;
        return y;
    endfunction

    task automatic voice_reset();
        vol = VOL_RESET;
        phase = 0;
        res1 = '{0, 0};
        res2 = '{0, 0};
        cur_vowel = 7;
        pos = 0;
        count = 0;
        pitch_a = 0;
        pitch_b = 0;
        armed = 0;
    endtask

    task automatic predict_voice(input logic [OP_W-1:0] op, input logic [F0_W-1:0] f0s,
                                 input logic [F0_W-1:0] f0e, input logic [VOWEL_W-1:0] vw,
                                 input logic [DUR_W-1:0] ms);
        longint t, p, num, f0q8, vib, inc, ph, exc, y1, y2, mix, e, env2, scaled, smp;
        int unsigned v;
        voice_sample_t r;
        if (op == OP_BEGIN || op == OP_BEGIN_NEW)
        begin
            if (op == OP_BEGIN_NEW)
            begin
                phase = 0;
                res1 = '{0, 0};
                res2 = '{0, 0};
                cur_vowel = 7;
            end
            if (vol == 0 || ms == 0)
            begin
                armed = 0;
                return;
            end
            cur_vowel = vw % 5;
            pitch_a = f0s;
            pitch_b = f0e;
            count = ms * 16;
            pos = 0;
            armed = 1;
            return;
        end
        if (op != OP_TICK || !armed) return;
        if (vol == 0)
        begin
            armed = 0;
            return;
        end
        t = count;
        p = pos;
        v = (cur_vowel < 5) ? cur_vowel : 0;
        num = (longint'(pitch_a) * t + (longint'(pitch_b) - longint'(pitch_a)) * p) * 256;
        f0q8 = num / t;
        vib = vib_gain(32'(p * 3076033));
        inc = (f0q8 * vib) / SAMPLE_RATE;
        ph = longint'(phase) + inc;
        exc = 0;
        if (ph >= 16777216)
        begin
            ph -= 16777216;
            exc = GLOTTAL;
        end
        else if (ph < 1342177) exc = PULSE_Q16;
        phase = 32'(ph & 24'hFFFFFF);
        y1 = resonate(res1, f1_b1[v], pole_b2[0], exc);
        y2 = resonate(res2, f2_b1[v], pole_b2[1], exc);
        mix = y1 * 12288 + y2 * 7373;
        if (p * 100 < 12 * t) e = (p * 100 * 65536) / (12 * t);
        else if (p * 100 > 72 * t) e = ((t - p) * 100 * 65536) / (28 * t);
        else e = 65536;
        env2 = (e * e) >> 16;
        scaled = (mix * level_k[vol]) / 16384;
        smp = (scaled * env2) / 64'sd4294967296;
        if (smp > CLIP_LEVEL) smp = CLIP_LEVEL;
        if (smp < -CLIP_LEVEL) smp = -CLIP_LEVEL;
        r.sample = smp[15:0];
        r.last = (p + 1 == t);
        pending_samples.push_back(r);
        pos++;
        if (pos >= count) armed = 0;
    endtask

    task automatic send_item(input logic [OP_W-1:0] op, input logic [F0_W-1:0] f0s,
                             input logic [F0_W-1:0] f0e, input logic [VOWEL_W-1:0] vw,
                             input logic [DUR_W-1:0] ms);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            syl_in.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        syl_in.valid       <= 1'b1;
        syl_in.operation   <= op;
        syl_in.f0_start    <= f0s;
        syl_in.f0_end      <= f0e;
        syl_in.vowel       <= vw;
        syl_in.duration_ms <= ms;
        do @(posedge clk); while (!syl_in.ready);
        predict_voice(op, f0s, f0e, vw, ms);
    endtask

    task automatic tick(input int n);
        repeat (n) send_item(OP_TICK, F0_W'($urandom), F0_W'($urandom), VOWEL_W'($urandom),
                             DUR_W'($urandom));
    endtask

    task automatic drain();
        syl_in.valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_volume(input logic [VOL_W-1:0] lv);
        drain();
        cfg.valid        <= 1'b1;
        cfg.volume_level <= lv;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        vol = lv;
    endtask

    task automatic test_directed();
        tick(1);
        send_item(OP_UNUSED, 12'hFFF, 12'hFFF, 8'hFF, 10'h3FF);
        send_item(OP_BEGIN, 12'd200, 12'd300, 8'd1, 10'd0);
        tick(1);
        send_item(OP_BEGIN_NEW, 12'd4095, 12'd0, 8'd255, 10'd1);
        tick(16);
        tick(1);
        send_item(OP_BEGIN, 12'd0, 12'd4095, 8'd0, 10'd1023);
        tick(2);
    endtask

    task automatic test_volume_levels();
        logic [VOL_W-1:0] lv;
        for (int i = 0; i < 4; i++)
        begin
            lv = (i == 0) ? 2'd3 : (i == 1) ? 2'd1 : (i == 2) ? 2'd0 : 2'd2;
            write_volume(lv);
            send_item(OP_BEGIN, F0_W'($urandom_range(80, 400)), F0_W'($urandom_range(80, 400)),
                      VOWEL_W'($urandom), 10'd1);
            tick(17);
        end
        // muted tick ends a running syllable
        send_item(OP_BEGIN, 12'd150, 12'd250, 8'd3, 10'd2);
        tick(3);
        write_volume(2'd0);
        tick(1);
        write_volume(2'd2);
        tick(2);
    endtask

    task automatic test_backpressure();
        send_item(OP_BEGIN, 12'd120, 12'd180, 8'd2, 10'd2);
        hold_req = 1'b1;
        tick(12);
        drain();
        tick(10);
    endtask

    task automatic test_random(input int n_items);
        int sent, n, t;
        logic [DUR_W-1:0] ms;
        sent = 0;
        while (sent < n_items)
        begin
            if (n_items - sent < 200) calm = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    send_item(OP_W'($urandom_range(0, 3)), F0_W'($urandom), F0_W'($urandom),
                              VOWEL_W'($urandom),
                              $urandom_range(0, 1) ? 10'd0 : 10'($urandom));
                    sent++;
                end
                1: begin
                    n = $urandom_range(1, 3);
                    tick(n);
                    sent += n;
                end
                default: begin
                    ms = ($urandom_range(0, 30) == 0) ? 10'($urandom) : 10'($urandom_range(1, 3));
                    send_item(OP_W'($urandom_range(0, 1)), F0_W'($urandom), F0_W'($urandom),
                              VOWEL_W'($urandom), ms);
                    t = (ms > 3) ? $urandom_range(1, 8) : ms * 16;
                    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, t + 2) : t;
                    tick(n);
                    sent += n + 1;
                end
            endcase
            if ($urandom_range(0, 40) == 0) drain();
        end
    endtask

    always @(posedge clk)
    begin
        voice_sample_t want;
        if (rst_n && smp_out.valid && smp_out.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("unexpected sample transaction: sample %0d last %0b",
                       smp_out.sample, smp_out.last_of_syllable);
                errors++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (smp_out.sample !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, smp_out.sample);
                    errors++;
                end
                if (smp_out.last_of_syllable !== want.last)
                begin
                    $error("last_of_syllable: expected %0b, got %0b", want.last,
                           smp_out.last_of_syllable);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int hold_left, stall_left;
        hold_left = 0;
        stall_left = 0;
        smp_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                smp_out.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                smp_out.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                smp_out.ready <= 1'b0;
            end
            else
                smp_out.ready <= 1'b1;
        end
    end

    initial
    begin
        #20_000_000;
        $display("formant_voice_synthesizer_tb: errors");
        $finish;
    end

    initial
    begin
        errors = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        voice_reset();
        rst_n <= 1'b0;
        syl_in.valid <= 1'b0;
        syl_in.operation <= OP_BEGIN;
        syl_in.f0_start <= '0;
        syl_in.f0_end <= '0;
        syl_in.vowel <= '0;
        syl_in.duration_ms <= '0;
        cfg.valid <= 1'b0;
        cfg.volume_level <= VOL_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_volume_levels();
        test_backpressure();
        test_random(1300);
        drain();

        if (errors == 0)
            $display("formant_voice_synthesizer_tb: clean");
        else
            $display("formant_voice_synthesizer_tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/fvs_pkg.sv
sv/fvs_if.sv
sv/fvs_divider.sv
sv/fvs_datapath.sv
sv/fvs_ctrl.sv
sv/formant_voice_synthesizer.sv
bench/formant_voice_synthesizer_tb.sv
